/* src/swac_pkg.sv */
package swac_pkg;

  // Field and register widths fixed by the interface.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int SIZE_W      = 7;
  localparam int THR_W       = 17;
  localparam int COUNT_W     = 17;
  localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [THR_W-1:0]  THR_RESET  = 17'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_CORNER,
    S_MID,
    S_READ,
    S_LAST,
    S_CMP,
    S_EMIT
  } swac_state_t;

  // Control from the sequencer to the shared window unit.
  typedef struct packed {
    logic clear;
    logic acc_en;
    logic acc_sub;
    logic mul_first;
    logic mul_second;
  } swac_wctl_t;

endpackage

/* src/swac_table.sv */
module swac_table #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int TBITS    = 28
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     wr_row,
  input  logic [$clog2(MAX_COLS+1)-1:0]     wr_col,
  input  logic [TBITS-1:0]                  wr_data,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     rd_row,
  input  logic [$clog2(MAX_COLS+1)-1:0]     rd_col,
  output logic [TBITS-1:0]                  rd_data
);
  import swac_pkg::*;

  localparam int STRIDE = MAX_COLS + 1;
  localparam int DEPTH  = (MAX_ROWS + 1) * (MAX_COLS + 1);
  localparam int AW     = $clog2(DEPTH);

  logic [TBITS-1:0] mem [DEPTH];
  logic [TBITS-1:0] rd_q;
  logic             border_q;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  assign wr_addr = AW'(wr_row) * AW'(STRIDE) + AW'(wr_col);
  assign rd_addr = AW'(rd_row) * AW'(STRIDE) + AW'(rd_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Row 0 and column 0 are never stored; they read as zero.
  always_ff @(posedge clk) begin
    rd_q     <= mem[rd_addr];
    border_q <= (rd_row == '0) || (rd_col == '0);
  end

  assign rd_data = border_q ? '0 : rd_q;

endmodule

/* src/swac_window_unit.sv */
module swac_window_unit #(
  parameter int TBITS = 28,
  parameter int SIDEW = 7
) (
  input  logic                         clk,
  input  swac_pkg::swac_wctl_t         ctl,
  input  logic [TBITS-1:0]             rd_data,
  input  logic [swac_pkg::THR_W-1:0]   threshold,
  input  logic [SIDEW-1:0]             mid,
  output logic                         below
);
  import swac_pkg::*;

  localparam int ACCW = TBITS + 2;
  localparam int PW1  = THR_W + SIDEW;
  localparam int PW2  = THR_W + 2 * SIDEW;
  localparam int CW   = (ACCW > PW2) ? ACCW : PW2;

  logic [ACCW-1:0] acc_r;
  logic [PW1-1:0]  p1_r;
  logic [PW2-1:0]  p2_r;

  // One add/subtract unit folds the four corner terms of a window in turn.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      if (ctl.acc_sub) begin
        acc_r <= acc_r - ACCW'(rd_data);
      end else begin
        acc_r <= acc_r + ACCW'(rd_data);
      end
    end
  end

  // threshold * side * side, one multiplication per cycle.
  always_ff @(posedge clk) begin
    if (ctl.mul_first) begin
      p1_r <= PW1'(threshold) * PW1'(mid);
    end
    if (ctl.mul_second) begin
      p2_r <= PW2'(p1_r) * PW2'(mid);
    end
  end

  // A negative window sum is always below the bound.
  assign below = acc_r[ACCW-1] || (CW'(acc_r) < CW'(p2_r));

endmodule

/* src/square_window_average_counter_top.sv */
// Channel  Direction  Word contents
// in_      slave      tdata: element_value; tlast: last_element
// out_     master     tdata: square_count
// cfg_     write      cfg_addr selects row_count, column_count, average_threshold
//
// Loading each word takes a read of the prefix entry above, then the write.
// Counting after the last word runs a binary search per corner; each probe reads the
// four corner terms in turn, bounded by the single table read port and the shared window unit.
// Reset (rst_n low, synchronous) clears control state; the table needs no clearing.
// Input is not ready while a word loads or counting runs; a waiting result only
// stalls the end of the next count.
module square_window_average_counter_top #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((ELEMENT_BITS+7)/8)*8-1:0]      in_tdata,   // element_value
  input  logic                                   in_tlast,   // last_element
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [swac_pkg::OUT_TDATA_W-1:0]       out_tdata,  // square_count
  input  logic                                   cfg_we,
  input  logic [swac_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [swac_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import swac_pkg::*;

  localparam int RIW     = $clog2(MAX_ROWS + 1);
  localparam int CIW     = $clog2(MAX_COLS + 1);
  localparam int RSW     = ELEMENT_BITS + $clog2(MAX_COLS);
  localparam int TBITS   = ELEMENT_BITS + $clog2(MAX_COLS) + $clog2(MAX_ROWS);
  localparam int MAXSIDE = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SIDEW   = $clog2(MAXSIDE + 1);

  swac_state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  row_count_r, column_count_r;
  logic [THR_W-1:0]   threshold_r;
  logic [RIW-1:0]     rows_eff;
  logic [CIW-1:0]     cols_eff;

  logic [RIW-1:0]     row_pos_r, row_pos_nxt;
  logic [CIW-1:0]     col_pos_r, col_pos_nxt;
  logic [RSW-1:0]     rrs_r, rrs_nxt;
  logic [RIW-1:0]     wr_row_r, wr_row_nxt;
  logic [CIW-1:0]     wr_col_r, wr_col_nxt;
  logic               last_r, last_nxt;

  logic [RIW-1:0]     i_r, i_nxt;
  logic [CIW-1:0]     j_r, j_nxt;
  logic [SIDEW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, top_r, top_nxt, mid_r, mid_nxt;
  logic [1:0]         q_r, q_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_data_r, out_data_nxt;

  logic [RIW-1:0]     rd_row;
  logic [CIW-1:0]     rd_col;
  logic [TBITS-1:0]   rd_data;
  logic               tbl_we;
  logic [TBITS-1:0]   tbl_wdata;
  swac_wctl_t         wctl;
  logic               below;

  logic [ELEMENT_BITS-1:0] elem;
  logic [CIW-1:0]     c_inc;
  logic [RIW-1:0]     r_inc;
  logic [RIW-1:0]     side_a;
  logic [CIW-1:0]     side_b;
  logic [SIDEW:0]     mid_sum;
  logic [RIW-1:0]     r2;
  logic [CIW-1:0]     c2;

  assign elem = in_tdata[ELEMENT_BITS-1:0];

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = RIW'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows_eff = RIW'(MAX_ROWS);
    end else begin
      rows_eff = RIW'(row_count_r);
    end
    if (column_count_r == '0) begin
      cols_eff = CIW'(1);
    end else if (int'(column_count_r) > MAX_COLS) begin
      cols_eff = CIW'(MAX_COLS);
    end else begin
      cols_eff = CIW'(column_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= SIZE_RESET;
      column_count_r <= SIZE_RESET;
      threshold_r    <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[SIZE_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  swac_table #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .TBITS    (TBITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_row  (wr_row_r),
    .wr_col  (wr_col_r),
    .wr_data (tbl_wdata),
    .rd_row  (rd_row),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  swac_window_unit #(
    .TBITS (TBITS),
    .SIDEW (SIDEW)
  ) u_window (
    .clk       (clk),
    .ctl       (wctl),
    .rd_data   (rd_data),
    .threshold (threshold_r),
    .mid       (mid_r),
    .below     (below)
  );

  assign tbl_wdata = rd_data + TBITS'(rrs_r);
  assign r2        = i_r + RIW'(mid_r) - RIW'(1);
  assign c2        = j_r + CIW'(mid_r) - CIW'(1);
  assign side_a    = rows_eff - i_r + RIW'(1);
  assign side_b    = cols_eff - j_r + CIW'(1);
  assign mid_sum   = (SIDEW+1)'(lo_r) + (SIDEW+1)'(hi_r) + (SIDEW+1)'(1);
  assign c_inc     = col_pos_r + CIW'(1);
  assign r_inc     = row_pos_r + RIW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      rrs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      rrs_r       <= rrs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r   <= wr_row_nxt;
    wr_col_r   <= wr_col_nxt;
    last_r     <= last_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    top_r      <= top_nxt;
    mid_r      <= mid_nxt;
    q_r        <= q_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    rrs_nxt       = rrs_r;
    wr_row_nxt    = wr_row_r;
    wr_col_nxt    = wr_col_r;
    last_nxt      = last_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    top_nxt       = top_r;
    mid_nxt       = mid_r;
    q_nxt         = q_r;
    total_nxt     = total_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    tbl_we        = 1'b0;
    rd_row        = row_pos_r;
    rd_col        = c_inc;
    wctl          = '0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // The read of the entry above is issued now and lands next cycle.
          rrs_nxt    = (col_pos_r == '0) ? RSW'(elem) : rrs_r + RSW'(elem);
          wr_row_nxt = r_inc;
          wr_col_nxt = c_inc;
          last_nxt   = in_tlast;
          if (c_inc >= cols_eff) begin
            col_pos_nxt = '0;
            row_pos_nxt = (r_inc >= rows_eff) ? '0 : r_inc;
          end else begin
            col_pos_nxt = c_inc;
            row_pos_nxt = (row_pos_r >= rows_eff) ? '0 : row_pos_r;
          end
          state_nxt = S_LOAD_WR;
        end
      end
      S_LOAD_WR: begin
        tbl_we = 1'b1;
        if (last_r) begin
          row_pos_nxt = '0;
          col_pos_nxt = '0;
          rrs_nxt     = '0;
          i_nxt       = RIW'(1);
          j_nxt       = CIW'(1);
          total_nxt   = '0;
          state_nxt   = S_CORNER;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CORNER: begin
        if (int'(side_a) < int'(side_b)) begin
          top_nxt = SIDEW'(side_a);
        end else begin
          top_nxt = SIDEW'(side_b);
        end
        lo_nxt    = '0;
        hi_nxt    = top_nxt;
        state_nxt = S_MID;
      end
      S_MID: begin
        if (lo_r < hi_r) begin
          mid_nxt    = mid_sum[SIDEW:1];
          wctl.clear = 1'b1;
          q_nxt      = '0;
          state_nxt  = S_READ;
        end else begin
          total_nxt = total_r + COUNT_W'(top_r - lo_r);
          if (j_r == cols_eff) begin
            j_nxt = CIW'(1);
            if (i_r == rows_eff) begin
              state_nxt = S_EMIT;
            end else begin
              i_nxt     = i_r + RIW'(1);
              state_nxt = S_CORNER;
            end
          end else begin
            j_nxt     = j_r + CIW'(1);
            state_nxt = S_CORNER;
          end
        end
      end
      S_READ: begin
        // Corner terms: bottom-right, bottom-left, top-right, top-left.
        case (q_r)
          2'd0: begin
            rd_row = r2;
            rd_col = c2;
          end
          2'd1: begin
            rd_row = r2;
            rd_col = j_r - CIW'(1);
          end
          2'd2: begin
            rd_row = i_r - RIW'(1);
            rd_col = c2;
          end
          default: begin
            rd_row = i_r - RIW'(1);
            rd_col = j_r - CIW'(1);
          end
        endcase
        // Read data arrives in the cycle after its address.
        wctl.mul_first  = (q_r == 2'd0);
        wctl.mul_second = (q_r == 2'd1);
        wctl.acc_en     = (q_r != 2'd0);
        wctl.acc_sub    = (q_r == 2'd2) || (q_r == 2'd3);
        q_nxt           = q_r + 2'd1;
        if (q_r == 2'd3) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        wctl.acc_en = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (below) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - SIDEW'(1);
        end
        state_nxt = S_MID;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = total_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  a_load_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MID) |-> (lo_r <= hi_r) && (hi_r <= top_r))
    else $error("binary search bounds out of order");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside the emit step");

  a_write_only_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> $past(in_tvalid && in_tready))
    else $error("table written without an accepted word");

endmodule
